FILE: sv/tsc_pkg.sv
// shared types, constants and helpers for the topological sorter
// no dependencies; the other design and bench files, tsc_ram apart, refer to it by scoped names

package tsc_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int NCNT_W    = $clog2(MAX_NODES + 1);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
    localparam int PEND_W    = $clog2(MAX_EDGES + 1);
    localparam int CFG_W     = 7;
    localparam int REG_IDX_W = 1;

    localparam logic [1:0] STATUS_ORDERED = 2'd0;
    localparam logic [1:0] STATUS_SORTED  = 2'd1;
    localparam logic [1:0] STATUS_CYCLE   = 2'd2;
    localparam logic [1:0] STATUS_REJECT  = 2'd3;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_PART_COUNT      = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_OPERATION_COUNT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NRD,
        ST_NGOT,
        ST_EGOT,
        ST_AUX,
        ST_PCLR,
        ST_SEED_RD,
        ST_SEED_CHK,
        ST_QRD,
        ST_QGOT,
        ST_EMIT_RD,
        ST_EMIT_PUT,
        ST_FIND,
        ST_SEEN_CHK,
        ST_SEEN_GOT,
        ST_FIX_GOT,
        ST_OP_RD,
        ST_OP_GOT,
        ST_CYC_PUT,
        ST_STAT_PUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_MIN,
        PH_CHK,
        PH_CNT,
        PH_KAHN,
        PH_UPRED
    } phase_t;

    typedef struct packed {
        logic [NCNT_W-1:0] n;
        logic [NCNT_W-1:0] p;
    } cfg_t;

    typedef struct packed {
        logic              add_en;
        logic [NODE_W-1:0] add_from;
        logic [NODE_W-1:0] add_to;
        logic              node_re;
        logic [NODE_W-1:0] node_addr;
        logic              edge_re;
        logic [EDGE_W-1:0] edge_addr;
        logic              clear;
    } edge_req_t;

    typedef struct packed {
        logic              full;
        logic              node_valid;
        logic [EDGE_W-1:0] node_head;
        logic [EDGE_W-1:0] node_tail;
        logic [NODE_W-1:0] edge_tgt;
        logic [EDGE_W-1:0] edge_nxt;
    } edge_rsp_t;

    // one end is a part and the other an operation, both in range
    function automatic logic live_edge(input logic [NCNT_W-1:0] src,
                                       input logic [NCNT_W-1:0] dst,
                                       input logic [NCNT_W-1:0] n,
                                       input logic [NCNT_W-1:0] p);
        return (src < n) && (dst < n) && ((src < p) != (dst < p));
    endfunction

endpackage

FILE: sv/tsc_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies

module tsc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tsc_edge_store.sv
// edge store: per-node successor lists in insertion order, one add per cycle
// depends on tsc_pkg and tsc_ram

module tsc_edge_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsc_pkg::edge_req_t req,
    output tsc_pkg::edge_rsp_t rsp
);

    logic [tsc_pkg::MAX_NODES-1:0] valid_reg, valid_next;
    logic [tsc_pkg::ECNT_W-1:0]    count_reg, count_next;
    logic                          link_pend_reg, link_pend_next;
    logic [tsc_pkg::EDGE_W-1:0]    link_edge_reg, link_edge_next;
    logic                          node_valid_reg, node_valid_next;

    logic [tsc_pkg::EDGE_W-1:0] cnt_idx;
    logic                       tail_re;
    logic [tsc_pkg::NODE_W-1:0] tail_raddr;
    logic [tsc_pkg::EDGE_W-1:0] head_rd, tail_rd, next_rd;
    logic [tsc_pkg::NODE_W-1:0] tgt_rd;
    logic                       head_we;

    assign cnt_idx = count_reg[tsc_pkg::EDGE_W-1:0];
    assign head_we = req.add_en && !valid_reg[req.add_from];

    // tail port serves the add path (old tail for the link) and the walker
    assign tail_re    = req.add_en || req.node_re;
    assign tail_raddr = req.add_en ? req.add_from : req.node_addr;

    tsc_ram #(.DEPTH(tsc_pkg::MAX_NODES), .WIDTH(tsc_pkg::EDGE_W)) u_head (
        .aclk (aclk),
        .we   (head_we),
        .waddr(req.add_from),
        .wdata(cnt_idx),
        .re   (req.node_re),
        .raddr(req.node_addr),
        .rdata(head_rd)
    );

    tsc_ram #(.DEPTH(tsc_pkg::MAX_NODES), .WIDTH(tsc_pkg::EDGE_W)) u_tail (
        .aclk (aclk),
        .we   (req.add_en),
        .waddr(req.add_from),
        .wdata(cnt_idx),
        .re   (tail_re),
        .raddr(tail_raddr),
        .rdata(tail_rd)
    );

    tsc_ram #(.DEPTH(tsc_pkg::MAX_EDGES), .WIDTH(tsc_pkg::NODE_W)) u_target (
        .aclk (aclk),
        .we   (req.add_en),
        .waddr(cnt_idx),
        .wdata(req.add_to),
        .re   (req.edge_re),
        .raddr(req.edge_addr),
        .rdata(tgt_rd)
    );

    // link old tail to the new edge in the cycle after the add
    tsc_ram #(.DEPTH(tsc_pkg::MAX_EDGES), .WIDTH(tsc_pkg::EDGE_W)) u_next (
        .aclk (aclk),
        .we   (link_pend_reg),
        .waddr(tail_rd),
        .wdata(link_edge_reg),
        .re   (req.edge_re),
        .raddr(req.edge_addr),
        .rdata(next_rd)
    );

    always_comb begin
        valid_next      = valid_reg;
        count_next      = count_reg;
        link_pend_next  = 1'b0;
        link_edge_next  = link_edge_reg;
        node_valid_next = node_valid_reg;
        if (req.add_en) begin
            valid_next[req.add_from] = 1'b1;
            count_next               = count_reg + 1'b1;
            link_pend_next           = valid_reg[req.add_from];
            link_edge_next           = cnt_idx;
        end
        if (req.node_re) begin
            node_valid_next = valid_reg[req.node_addr];
        end
        if (req.clear) begin
            valid_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            link_pend_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            link_pend_reg <= link_pend_next;
        end
        link_edge_reg  <= link_edge_next;
        node_valid_reg <= node_valid_next;
    end

    assign rsp.full       = count_reg >= tsc_pkg::ECNT_W'(tsc_pkg::MAX_EDGES);
    assign rsp.node_valid = node_valid_reg;
    assign rsp.node_head  = head_rd;
    assign rsp.node_tail  = tail_rd;
    assign rsp.edge_tgt   = tgt_rd;
    assign rsp.edge_nxt   = next_rd;

endmodule

FILE: sv/tsc_ctrl.sv
// run sequencer: edge adds and rejects, order check, kahn sort, cycle search, result register
// depends on tsc_pkg, tsc_ram and the edge store responses

module tsc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tsc_pkg::cfg_t              cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [tsc_pkg::NODE_W-1:0] s_from_node,
    input  logic [tsc_pkg::NODE_W-1:0] s_to_node,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [tsc_pkg::NODE_W-1:0] m_sorted_node,
    output logic [tsc_pkg::NODE_W-1:0] m_cycle_part,
    output logic [tsc_pkg::NODE_W-1:0] m_cycle_operation,
    output logic                       m_last,
    output tsc_pkg::edge_req_t         ereq,
    input  tsc_pkg::edge_rsp_t         ersp
);

    localparam int NW = tsc_pkg::NODE_W;
    localparam int CW = tsc_pkg::NCNT_W;
    localparam int EW = tsc_pkg::EDGE_W;
    localparam int PW = tsc_pkg::PEND_W;
    localparam logic [CW-1:0] NODES_C = CW'(tsc_pkg::MAX_NODES);
    localparam logic [CW-1:0] LAST_C  = CW'(tsc_pkg::MAX_NODES - 1);

    tsc_pkg::ctrl_state_t state_reg, state_next;
    tsc_pkg::phase_t      phase_reg, phase_next;

    logic [CW-1:0] v_reg, v_next;
    logic [EW-1:0] e_reg, e_next;
    logic [EW-1:0] tail_reg, tail_next;
    logic [EW-1:0] nxt_reg, nxt_next;
    logic          last_e_reg, last_e_next;
    logic [NW-1:0] s_reg, s_next;
    logic          live_reg, live_next;
    logic [CW-1:0] m_reg, m_next;
    logic          bad_reg, bad_next;
    logic [CW-1:0] qt_reg, qt_next;
    logic [CW-1:0] qh_reg, qh_next;
    logic [CW-1:0] k_reg, k_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] start_reg, start_next;
    logic [NW-1:0] op_reg, op_next;
    logic [tsc_pkg::MAX_NODES-1:0] done_reg, done_next;
    logic [tsc_pkg::MAX_NODES-1:0] seen_reg, seen_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [NW-1:0] out_node_reg, out_node_next;
    logic [NW-1:0] out_part_reg, out_part_next;
    logic [NW-1:0] out_op_reg, out_op_next;
    logic          out_last_reg, out_last_next;
    logic          out_free, out_load;

    logic          min_we, min_re;
    logic [NW-1:0] min_waddr, min_raddr;
    logic [CW-1:0] min_wdata, min_rd;
    logic          pend_we, pend_re;
    logic [NW-1:0] pend_waddr, pend_raddr;
    logic [PW-1:0] pend_wdata, pend_rd;
    logic          queue_we, queue_re;
    logic [NW-1:0] queue_waddr, queue_raddr;
    logic [NW-1:0] queue_wdata, queue_rd;
    logic          upred_we, upred_re;
    logic [NW-1:0] upred_waddr, upred_raddr;
    logic [NW-1:0] upred_wdata, upred_rd;

    logic          node_end;
    logic          live_now, last_now, cyc_last;
    logic [CW-1:0] tgt_ext, m_new;
    logic [NW-1:0] v6;

    tsc_ram #(.DEPTH(tsc_pkg::MAX_NODES), .WIDTH(CW)) u_min (
        .aclk(aclk), .we(min_we), .waddr(min_waddr), .wdata(min_wdata),
        .re(min_re), .raddr(min_raddr), .rdata(min_rd)
    );
    tsc_ram #(.DEPTH(tsc_pkg::MAX_NODES), .WIDTH(PW)) u_pend (
        .aclk(aclk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
        .re(pend_re), .raddr(pend_raddr), .rdata(pend_rd)
    );
    tsc_ram #(.DEPTH(tsc_pkg::MAX_NODES), .WIDTH(NW)) u_queue (
        .aclk(aclk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .re(queue_re), .raddr(queue_raddr), .rdata(queue_rd)
    );
    tsc_ram #(.DEPTH(tsc_pkg::MAX_NODES), .WIDTH(NW)) u_upred (
        .aclk(aclk), .we(upred_we), .waddr(upred_waddr), .wdata(upred_wdata),
        .re(upred_re), .raddr(upred_raddr), .rdata(upred_rd)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign v6       = v_reg[NW-1:0];
    assign tgt_ext  = {1'b0, ersp.edge_tgt};
    assign live_now = tsc_pkg::live_edge(v_reg, tgt_ext, cfg.n, cfg.p);
    assign last_now = e_reg == tail_reg;
    assign m_new    = (live_now && (tgt_ext < m_reg)) ? tgt_ext : m_reg;
    assign cyc_last = (upred_rd == start_reg) || (k_reg == LAST_C);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        v_next      = v_reg;
        e_next      = e_reg;
        tail_next   = tail_reg;
        nxt_next    = nxt_reg;
        last_e_next = last_e_reg;
        s_next      = s_reg;
        live_next   = live_reg;
        m_next      = m_reg;
        bad_next    = bad_reg;
        qt_next     = qt_reg;
        qh_next     = qh_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        start_next  = start_reg;
        op_next     = op_reg;
        done_next   = done_reg;
        seen_next   = seen_reg;

        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_node_next   = out_node_reg;
        out_part_next   = out_part_reg;
        out_op_next     = out_op_reg;
        out_last_next   = out_last_reg;

        s_ready  = 1'b0;
        node_end = 1'b0;
        ereq     = '0;

        min_we = 1'b0; min_waddr = v6; min_wdata = m_reg;
        min_re = 1'b0; min_raddr = ersp.edge_tgt;
        pend_we = 1'b0; pend_waddr = s_reg; pend_wdata = '0;
        pend_re = 1'b0; pend_raddr = ersp.edge_tgt;
        queue_we = 1'b0; queue_waddr = qt_reg[NW-1:0]; queue_wdata = s_reg;
        queue_re = 1'b0; queue_raddr = qh_reg[NW-1:0];
        upred_we = 1'b0; upred_waddr = ersp.edge_tgt; upred_wdata = v6;
        upred_re = 1'b0; upred_raddr = cur_reg;

        unique case (state_reg)
            tsc_pkg::ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (s_kind == tsc_pkg::KIND_RUN) begin
                        phase_next = tsc_pkg::PH_MIN;
                        v_next     = '0;
                        state_next = tsc_pkg::ST_NRD;
                    end else if (!tsc_pkg::live_edge({1'b0, s_from_node},
                                                     {1'b0, s_to_node},
                                                     cfg.n, cfg.p) || ersp.full) begin
                        out_load        = 1'b1;
                        out_status_next = tsc_pkg::STATUS_REJECT;
                        out_node_next   = '0;
                        out_part_next   = '0;
                        out_op_next     = '0;
                        out_last_next   = 1'b1;
                    end else begin
                        ereq.add_en   = 1'b1;
                        ereq.add_from = s_from_node;
                        ereq.add_to   = s_to_node;
                    end
                end
            end

            tsc_pkg::ST_NRD: begin
                if (v_reg >= cfg.n) begin
                    unique case (phase_reg)
                        tsc_pkg::PH_MIN: begin
                            phase_next = tsc_pkg::PH_CHK;
                            v_next     = '0;
                            bad_next   = 1'b0;
                        end
                        tsc_pkg::PH_CHK: begin
                            v_next     = '0;
                            state_next = bad_reg ? tsc_pkg::ST_PCLR
                                                 : tsc_pkg::ST_STAT_PUT;
                        end
                        tsc_pkg::PH_CNT: begin
                            v_next     = '0;
                            qt_next    = '0;
                            state_next = tsc_pkg::ST_SEED_RD;
                        end
                        tsc_pkg::PH_UPRED: begin
                            v_next     = '0;
                            state_next = tsc_pkg::ST_FIND;
                        end
                        default: begin
                            state_next = tsc_pkg::ST_IDLE;
                        end
                    endcase
                end else if (phase_reg == tsc_pkg::PH_UPRED && done_reg[v6]) begin
                    v_next = v_reg + 1'b1;
                end else begin
                    ereq.node_re   = 1'b1;
                    ereq.node_addr = v6;
                    state_next     = tsc_pkg::ST_NGOT;
                end
            end

            tsc_pkg::ST_NGOT: begin
                if (!ersp.node_valid) begin
                    min_we    = phase_reg == tsc_pkg::PH_MIN;
                    min_wdata = cfg.n;
                    node_end  = 1'b1;
                end else begin
                    ereq.edge_re   = 1'b1;
                    ereq.edge_addr = ersp.node_head;
                    e_next         = ersp.node_head;
                    tail_next      = ersp.node_tail;
                    m_next         = cfg.n;
                    state_next     = tsc_pkg::ST_EGOT;
                end
            end

            tsc_pkg::ST_EGOT: begin
                if (phase_reg == tsc_pkg::PH_MIN || phase_reg == tsc_pkg::PH_UPRED) begin
                    if (phase_reg == tsc_pkg::PH_MIN) begin
                        m_next    = m_new;
                        min_we    = last_now;
                        min_wdata = m_new;
                    end else begin
                        upred_we = live_now;
                    end
                    if (last_now) begin
                        node_end = 1'b1;
                    end else begin
                        ereq.edge_re   = 1'b1;
                        ereq.edge_addr = ersp.edge_nxt;
                        e_next         = ersp.edge_nxt;
                    end
                end else begin
                    s_next      = ersp.edge_tgt;
                    live_next   = live_now;
                    nxt_next    = ersp.edge_nxt;
                    last_e_next = last_now;
                    min_re      = phase_reg == tsc_pkg::PH_CHK;
                    pend_re     = phase_reg != tsc_pkg::PH_CHK;
                    state_next  = tsc_pkg::ST_AUX;
                end
            end

            tsc_pkg::ST_AUX: begin
                case (phase_reg)
                    tsc_pkg::PH_CHK: begin
                        if (live_reg && v_reg >= min_rd) begin
                            bad_next = 1'b1;
                        end
                    end
                    tsc_pkg::PH_CNT: begin
                        pend_we    = live_reg;
                        pend_wdata = pend_rd + 1'b1;
                    end
                    tsc_pkg::PH_KAHN: begin
                        if (live_reg && pend_rd != '0) begin
                            pend_we    = 1'b1;
                            pend_wdata = pend_rd - 1'b1;
                            if (pend_rd == PW'(1) && qt_reg < NODES_C) begin
                                queue_we = 1'b1;
                                qt_next  = qt_reg + 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (last_e_reg) begin
                    node_end = 1'b1;
                end else begin
                    ereq.edge_re   = 1'b1;
                    ereq.edge_addr = nxt_reg;
                    e_next         = nxt_reg;
                    state_next     = tsc_pkg::ST_EGOT;
                end
            end

            tsc_pkg::ST_PCLR: begin
                pend_we    = 1'b1;
                pend_waddr = v6;
                pend_wdata = '0;
                done_next  = '0;
                if (v_reg == LAST_C) begin
                    v_next     = '0;
                    phase_next = tsc_pkg::PH_CNT;
                    state_next = tsc_pkg::ST_NRD;
                end else begin
                    v_next = v_reg + 1'b1;
                end
            end

            tsc_pkg::ST_SEED_RD: begin
                if (v_reg >= cfg.n) begin
                    qh_next    = '0;
                    phase_next = tsc_pkg::PH_KAHN;
                    state_next = tsc_pkg::ST_QRD;
                end else begin
                    pend_re    = 1'b1;
                    pend_raddr = v6;
                    state_next = tsc_pkg::ST_SEED_CHK;
                end
            end

            tsc_pkg::ST_SEED_CHK: begin
                if (pend_rd == '0 && qt_reg < NODES_C) begin
                    queue_we    = 1'b1;
                    queue_wdata = v6;
                    qt_next     = qt_reg + 1'b1;
                end
                v_next     = v_reg + 1'b1;
                state_next = tsc_pkg::ST_SEED_RD;
            end

            tsc_pkg::ST_QRD: begin
                if (qh_reg < qt_reg) begin
                    queue_re   = 1'b1;
                    qh_next    = qh_reg + 1'b1;
                    state_next = tsc_pkg::ST_QGOT;
                end else if (qt_reg >= cfg.n) begin
                    k_next     = '0;
                    state_next = tsc_pkg::ST_EMIT_RD;
                end else begin
                    v_next     = '0;
                    phase_next = tsc_pkg::PH_UPRED;
                    state_next = tsc_pkg::ST_NRD;
                end
            end

            tsc_pkg::ST_QGOT: begin
                v_next              = {1'b0, queue_rd};
                done_next[queue_rd] = 1'b1;
                ereq.node_re        = 1'b1;
                ereq.node_addr      = queue_rd;
                state_next          = tsc_pkg::ST_NGOT;
            end

            tsc_pkg::ST_EMIT_RD: begin
                queue_re    = 1'b1;
                queue_raddr = k_reg[NW-1:0];
                state_next  = tsc_pkg::ST_EMIT_PUT;
            end

            tsc_pkg::ST_EMIT_PUT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = tsc_pkg::STATUS_SORTED;
                    out_node_next   = queue_rd;
                    out_part_next   = '0;
                    out_op_next     = '0;
                    out_last_next   = (k_reg + 1'b1) == cfg.n;
                    if ((k_reg + 1'b1) == cfg.n) begin
                        ereq.clear = 1'b1;
                        state_next = tsc_pkg::ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = tsc_pkg::ST_EMIT_RD;
                    end
                end
            end

            tsc_pkg::ST_FIND: begin
                if (!done_reg[v6]) begin
                    cur_next   = v6;
                    seen_next  = '0;
                    state_next = tsc_pkg::ST_SEEN_CHK;
                end else begin
                    v_next = v_reg + 1'b1;
                end
            end

            tsc_pkg::ST_SEEN_CHK: begin
                upred_re = 1'b1;
                if (seen_reg[cur_reg]) begin
                    if ({1'b0, cur_reg} >= cfg.p) begin
                        state_next = tsc_pkg::ST_FIX_GOT;
                    end else begin
                        upred_re   = 1'b0;
                        start_next = cur_reg;
                        k_next     = '0;
                        state_next = tsc_pkg::ST_OP_RD;
                    end
                end else begin
                    seen_next[cur_reg] = 1'b1;
                    state_next         = tsc_pkg::ST_SEEN_GOT;
                end
            end

            tsc_pkg::ST_SEEN_GOT: begin
                cur_next   = upred_rd;
                state_next = tsc_pkg::ST_SEEN_CHK;
            end

            tsc_pkg::ST_FIX_GOT: begin
                cur_next   = upred_rd;
                start_next = upred_rd;
                k_next     = '0;
                state_next = tsc_pkg::ST_OP_RD;
            end

            tsc_pkg::ST_OP_RD: begin
                upred_re   = 1'b1;
                state_next = tsc_pkg::ST_OP_GOT;
            end

            tsc_pkg::ST_OP_GOT: begin
                op_next     = upred_rd;
                upred_re    = 1'b1;
                upred_raddr = upred_rd;
                state_next  = tsc_pkg::ST_CYC_PUT;
            end

            tsc_pkg::ST_CYC_PUT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = tsc_pkg::STATUS_CYCLE;
                    out_node_next   = '0;
                    out_part_next   = cur_reg;
                    out_op_next     = op_reg;
                    out_last_next   = cyc_last;
                    if (cyc_last) begin
                        ereq.clear = 1'b1;
                        state_next = tsc_pkg::ST_IDLE;
                    end else begin
                        cur_next   = upred_rd;
                        k_next     = k_reg + 1'b1;
                        state_next = tsc_pkg::ST_OP_RD;
                    end
                end
            end

            tsc_pkg::ST_STAT_PUT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = tsc_pkg::STATUS_ORDERED;
                    out_node_next   = '0;
                    out_part_next   = '0;
                    out_op_next     = '0;
                    out_last_next   = 1'b1;
                    ereq.clear      = 1'b1;
                    state_next      = tsc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tsc_pkg::ST_IDLE;
            end
        endcase

        // node walk finished: next node, or back to the queue in the sort
        if (node_end) begin
            if (phase_reg == tsc_pkg::PH_KAHN) begin
                state_next = tsc_pkg::ST_QRD;
            end else begin
                v_next     = v_reg + 1'b1;
                state_next = tsc_pkg::ST_NRD;
            end
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tsc_pkg::ST_IDLE;
            phase_reg     <= tsc_pkg::PH_MIN;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            seen_reg      <= '0;
            bad_reg       <= 1'b0;
            qt_reg        <= '0;
            qh_reg        <= '0;
            k_reg         <= '0;
            v_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
            seen_reg      <= seen_next;
            bad_reg       <= bad_next;
            qt_reg        <= qt_next;
            qh_reg        <= qh_next;
            k_reg         <= k_next;
            v_reg         <= v_next;
        end
        e_reg          <= e_next;
        tail_reg       <= tail_next;
        nxt_reg        <= nxt_next;
        last_e_reg     <= last_e_next;
        s_reg          <= s_next;
        live_reg       <= live_next;
        m_reg          <= m_next;
        cur_reg        <= cur_next;
        start_reg      <= start_next;
        op_reg         <= op_next;
        out_status_reg <= out_status_next;
        out_node_reg   <= out_node_next;
        out_part_reg   <= out_part_next;
        out_op_reg     <= out_op_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_status_reg;
    assign m_sorted_node     = out_node_reg;
    assign m_cycle_part      = out_part_reg;
    assign m_cycle_operation = out_op_reg;
    assign m_last            = out_last_reg;

endmodule

FILE: sv/topological_sort_with_cycle_find.sv
// channel   direction  ports
// input     in         s_valid/s_ready, s_kind, s_from_node, s_to_node
// result    out        m_valid/m_ready, m_status, m_sorted_node, m_cycle_part,
//                      m_cycle_operation, m_last
// config    in         cfg_valid/cfg_ready, cfg_index, cfg_wdata
//
// edge adds are accepted back to back while the result register is free
// a run walks the lists for the minima, then for the check; if out of order it clears all 64
// pending counters, walks the lists for the count, seeds the queue and sorts, and if nodes
// are left over walks the lists for cycle links; it then puts the sorted words or cycle pairs
// reset clears control state and all lists at once; no clearing pass; a stalled result
// word holds the sequencer only where it loads the next word or takes an input word
// depends on tsc_pkg, tsc_edge_store, tsc_ctrl

module topological_sort_with_cycle_find (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [tsc_pkg::NODE_W-1:0]    s_from_node,
    input  logic [tsc_pkg::NODE_W-1:0]    s_to_node,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [tsc_pkg::NODE_W-1:0]    m_sorted_node,
    output logic [tsc_pkg::NODE_W-1:0]    m_cycle_part,
    output logic [tsc_pkg::NODE_W-1:0]    m_cycle_operation,
    output logic                          m_last
);

    logic [tsc_pkg::CFG_W-1:0] part_count_reg, part_count_next;
    logic [tsc_pkg::CFG_W-1:0] operation_count_reg, operation_count_next;
    logic [tsc_pkg::CFG_W:0]   total;
    tsc_pkg::cfg_t             cfg;
    tsc_pkg::edge_req_t        ereq;
    tsc_pkg::edge_rsp_t        ersp;

    assign cfg_ready = 1'b1;

    always_comb begin
        part_count_next      = part_count_reg;
        operation_count_next = operation_count_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tsc_pkg::REG_PART_COUNT:      part_count_next      = cfg_wdata;
                tsc_pkg::REG_OPERATION_COUNT: operation_count_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_count_reg      <= '0;
            operation_count_reg <= '0;
        end else begin
            part_count_reg      <= part_count_next;
            operation_count_reg <= operation_count_next;
        end
    end

    // node total clamps at the store size, parts clamp at the node total
    assign total = {1'b0, part_count_reg} + {1'b0, operation_count_reg};
    assign cfg.n = (total > (tsc_pkg::CFG_W + 1)'(tsc_pkg::MAX_NODES))
                 ? tsc_pkg::NCNT_W'(tsc_pkg::MAX_NODES) : total[tsc_pkg::NCNT_W-1:0];
    assign cfg.p = (part_count_reg > cfg.n) ? cfg.n : part_count_reg;

    tsc_edge_store u_edges (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (ereq),
        .rsp    (ersp)
    );

    tsc_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_from_node      (s_from_node),
        .s_to_node        (s_to_node),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_sorted_node    (m_sorted_node),
        .m_cycle_part     (m_cycle_part),
        .m_cycle_operation(m_cycle_operation),
        .m_last           (m_last),
        .ereq             (ereq),
        .ersp             (ersp)
    );

endmodule

FILE: sv/tsc_checker.sv
// port-level checks for the topological sorter, bound to the top level
// depends on tsc_pkg

module tsc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [tsc_pkg::REG_IDX_W-1:0] cfg_index,
    input logic [tsc_pkg::CFG_W-1:0]     cfg_wdata,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_kind,
    input logic [tsc_pkg::NODE_W-1:0]    s_from_node,
    input logic [tsc_pkg::NODE_W-1:0]    s_to_node,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic [tsc_pkg::NODE_W-1:0]    m_sorted_node,
    input logic [tsc_pkg::NODE_W-1:0]    m_cycle_part,
    input logic [tsc_pkg::NODE_W-1:0]    m_cycle_operation,
    input logic                          m_last
);

    // a stalled result word holds its valid, status, last, sorted node and cycle part
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_last)
            && $stable(m_sorted_node) && $stable(m_cycle_part))
        else $error("result word changed while stalled");

    // in-order and rejected words end their item
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == tsc_pkg::STATUS_ORDERED
                    || m_status == tsc_pkg::STATUS_REJECT) |-> m_last)
        else $error("single-word result without last");

    // the sorted node field stays zero outside the sorted status
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != tsc_pkg::STATUS_SORTED |-> m_sorted_node == '0)
        else $error("sorted node set on other status");

    // a run keeps the input closed the next cycle
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == tsc_pkg::KIND_RUN |=> !s_ready)
        else $error("input open right after a run word");

endmodule

bind topological_sort_with_cycle_find tsc_checker u_tsc_checker (.*);

FILE: dv/topological_sort_with_cycle_find_checker.sv
// result checker for topological_sort_with_cycle_find: tracks config writes and input words,
// predicts the result words of each input word and compares them with the output channel
// depends on tsc_pkg
`timescale 1ns / 100ps

module topological_sort_with_cycle_find_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tsc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_kind,
    input  logic [tsc_pkg::NODE_W-1:0]    s_from_node,
    input  logic [tsc_pkg::NODE_W-1:0]    s_to_node,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_status,
    input  logic [tsc_pkg::NODE_W-1:0]    m_sorted_node,
    input  logic [tsc_pkg::NODE_W-1:0]    m_cycle_part,
    input  logic [tsc_pkg::NODE_W-1:0]    m_cycle_operation,
    input  logic                          m_last,
    output int                            fail_count,
    output int                            words_owed
);

    localparam int NIL = tsc_pkg::MAX_EDGES;

    typedef struct {
        logic [1:0] status;
        logic [5:0] node;
        logic [5:0] part;
        logic [5:0] op;
        logic       last;
    } sort_word_t;

    sort_word_t owed_words[$];

    int parts_reg, ops_reg;
    int tgt_mem [tsc_pkg::MAX_EDGES];
    int nxt_mem [tsc_pkg::MAX_EDGES];
    int head_mem[tsc_pkg::MAX_NODES];
    int tail_mem[tsc_pkg::MAX_NODES];
    int n_edges;
    int preds_left[tsc_pkg::MAX_NODES];
    int order_q[tsc_pkg::MAX_NODES];
    bit finished[tsc_pkg::MAX_NODES];
    int back_link[tsc_pkg::MAX_NODES];
    int min_place[tsc_pkg::MAX_NODES];

    assign words_owed = owed_words.size();

    function automatic bit crosses(int a, int b, int n, int p);
        return a < n && b < n && ((a < p) != (b < p));
    endfunction

    function automatic int head_of(int v);
        return head_mem[v] < n_edges ? head_mem[v] : NIL;
    endfunction

    function automatic int after(int e);
        return nxt_mem[e] < n_edges ? nxt_mem[e] : NIL;
    endfunction

    function automatic void owe(logic [1:0] st, int node, int part, int op, bit lst);
        sort_word_t w;
        w.status = st;
        w.node = node[5:0];
        w.part = part[5:0];
        w.op = op[5:0];
        w.last = lst;
        owed_words.push_back(w);
    endfunction

    function automatic void drop_edges();
        n_edges = 0;
        for (int v = 0; v < tsc_pkg::MAX_NODES; v++) begin
            head_mem[v] = NIL;
            tail_mem[v] = NIL;
        end
    endfunction

    function automatic void wipe();
        parts_reg = 0;
        ops_reg = 0;
        for (int i = 0; i < tsc_pkg::MAX_EDGES; i++) begin
            tgt_mem[i] = 0;
            nxt_mem[i] = 0;
        end
        for (int v = 0; v < tsc_pkg::MAX_NODES; v++) begin
            preds_left[v] = 0;
            order_q[v] = 0;
            finished[v] = 0;
            back_link[v] = 0;
            min_place[v] = 0;
        end
        drop_edges();
        owed_words.delete();
    endfunction

    // works out the result words one input word causes
    function automatic void sort_predict(bit kind, int from, int to);
        int n, p, v, e, s, m, qh, qt, k, start, part, op;
        bit ordered;
        bit seen[tsc_pkg::MAX_NODES];
        n = parts_reg + ops_reg;
        if (n > tsc_pkg::MAX_NODES) n = tsc_pkg::MAX_NODES;
        p = parts_reg > n ? n : parts_reg;
        ordered = 1;
        if (kind == tsc_pkg::KIND_ADD) begin
            if (!crosses(from, to, n, p) || n_edges >= tsc_pkg::MAX_EDGES) begin
                owe(tsc_pkg::STATUS_REJECT, 0, 0, 0, 1);
                return;
            end
            e = n_edges;
            n_edges++;
            tgt_mem[e] = to;
            nxt_mem[e] = NIL;
            if (head_mem[from] >= n_edges - 1 || head_mem[from] >= NIL) head_mem[from] = e;
            else nxt_mem[tail_mem[from]] = e;
            tail_mem[from] = e;
            return;
        end
        // numbering check: a successor of a successor must come after the node itself
        for (v = 0; v < n; v++) begin
            m = n;
            for (e = head_of(v); e < NIL; e = after(e)) begin
                s = tgt_mem[e];
                if (crosses(v, s, n, p) && s < m) m = s;
            end
            min_place[v] = m;
        end
        for (v = 0; v < n && ordered; v++)
            for (e = head_of(v); e < NIL; e = after(e)) begin
                s = tgt_mem[e];
                if (crosses(v, s, n, p) && v >= min_place[s]) begin
                    ordered = 0;
                    break;
                end
            end
        if (ordered) begin
            drop_edges();
            owe(tsc_pkg::STATUS_ORDERED, 0, 0, 0, 1);
            return;
        end
        for (v = 0; v < tsc_pkg::MAX_NODES; v++) begin
            preds_left[v] = 0;
            finished[v] = 0;
        end
        for (v = 0; v < n; v++)
            for (e = head_of(v); e < NIL; e = after(e)) begin
                s = tgt_mem[e];
                if (crosses(v, s, n, p)) preds_left[s]++;
            end
        qt = 0;
        for (v = 0; v < n; v++)
            if (preds_left[v] == 0 && qt < tsc_pkg::MAX_NODES) order_q[qt++] = v;
        qh = 0;
        while (qh < qt) begin
            v = order_q[qh++];
            finished[v] = 1;
            for (e = head_of(v); e < NIL; e = after(e)) begin
                s = tgt_mem[e];
                if (!crosses(v, s, n, p) || preds_left[s] == 0) continue;
                preds_left[s]--;
                if (preds_left[s] == 0 && qt < tsc_pkg::MAX_NODES) order_q[qt++] = s;
            end
        end
        if (qt >= n) begin
            for (k = 0; k < n; k++)
                owe(tsc_pkg::STATUS_SORTED, order_q[k], 0, 0, k + 1 == n);
            drop_edges();
            return;
        end
        // cycle walk over the last unsorted predecessor of each node
        for (v = 0; v < n; v++)
            if (!finished[v])
                for (e = head_of(v); e < NIL; e = after(e)) begin
                    s = tgt_mem[e];
                    if (crosses(v, s, n, p)) back_link[s] = v;
                end
        for (v = 0; v < n && finished[v]; v++) ;
        for (int i = 0; i < tsc_pkg::MAX_NODES; i++) seen[i] = 0;
        v = v % tsc_pkg::MAX_NODES;
        while (!seen[v]) begin
            seen[v] = 1;
            v = back_link[v] % tsc_pkg::MAX_NODES;
        end
        if (v >= p) v = back_link[v] % tsc_pkg::MAX_NODES;
        start = v;
        part = start;
        k = 0;
        do begin
            op = back_link[part] % tsc_pkg::MAX_NODES;
            k++;
            part = back_link[op] % tsc_pkg::MAX_NODES;
            owe(tsc_pkg::STATUS_CYCLE, 0, v, op,
                !(part != start && k < tsc_pkg::MAX_NODES));
            v = part;
        end while (part != start && k < tsc_pkg::MAX_NODES);
        drop_edges();
    endfunction

    always @(posedge aclk) begin
        sort_word_t w;
        if (!aresetn) begin
            wipe();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tsc_pkg::REG_PART_COUNT) parts_reg = cfg_wdata;
                else ops_reg = cfg_wdata;
            end
            if (s_valid && s_ready) sort_predict(s_kind, s_from_node, s_to_node);
            if (m_valid && m_ready) begin
                if (owed_words.size() == 0) begin
                    $error("result word with nothing expected, status %0d", m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    w = owed_words.pop_front();
                    if (m_status !== w.status) begin
                        $error("status expected %0d actual %0d", w.status, m_status);
                        fail_count <= fail_count + 1;
                    end
                    if (m_sorted_node !== w.node) begin
                        $error("sorted_node expected %0d actual %0d", w.node, m_sorted_node);
                        fail_count <= fail_count + 1;
                    end
                    if (m_cycle_part !== w.part) begin
                        $error("cycle_part expected %0d actual %0d", w.part, m_cycle_part);
                        fail_count <= fail_count + 1;
                    end
                    if (m_cycle_operation !== w.op) begin
                        $error("cycle_operation expected %0d actual %0d", w.op,
                               m_cycle_operation);
                        fail_count <= fail_count + 1;
                    end
                    if (m_last !== w.last) begin
                        $error("last expected %0d actual %0d", w.last, m_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/topological_sort_with_cycle_find_test.sv
// testbench top for topological_sort_with_cycle_find: clock, reset, edge/run stimulus,
// config phases, output stalls and the verdict; depends on tsc_pkg, the design top and the checker module
`timescale 1ns / 100ps

module topological_sort_with_cycle_find_test;

    localparam int IDLE_LIMIT = 30000;
    localparam int ITEM_GOAL  = 450;

    logic                          aclk = 0;
    logic                          aresetn = 0;
    logic                          cfg_valid = 0;
    logic                          cfg_ready;
    logic [tsc_pkg::REG_IDX_W-1:0] cfg_index = tsc_pkg::REG_PART_COUNT;
    logic [tsc_pkg::CFG_W-1:0]     cfg_wdata = 0;
    logic                          s_valid = 0;
    logic                          s_ready;
    logic                          s_kind = tsc_pkg::KIND_ADD;
    logic [tsc_pkg::NODE_W-1:0]    s_from_node = 0;
    logic [tsc_pkg::NODE_W-1:0]    s_to_node = 0;
    logic                          m_valid;
    logic                          m_ready = 0;
    logic [1:0]                    m_status;
    logic [tsc_pkg::NODE_W-1:0]    m_sorted_node;
    logic [tsc_pkg::NODE_W-1:0]    m_cycle_part;
    logic [tsc_pkg::NODE_W-1:0]    m_cycle_operation;
    logic                          m_last;
    int                            fail_count;
    int                            words_owed;

    bit quiet = 0;
    bit hold_req = 0;
    int sent = 0;
    int idle_cycles = 0;
    int cur_parts = 0, cur_ops = 0;

    always #5 aclk = ~aclk;

    topological_sort_with_cycle_find u_dut (.*);

    topological_sort_with_cycle_find_checker u_chk (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("topological_sort_with_cycle_find verification failed");
            $finish;
        end
    end

    // output side: random stall bursts, one long hold on request
    initial begin
        @(posedge aresetn);
        forever begin
            m_ready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (hold_req) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
        end
    end

    task automatic push_word(logic kind, int from, int to);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1;
        s_kind <= kind;
        s_from_node <= from[5:0];
        s_to_node <= to[5:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic settle();
        s_valid <= 0;
        @(posedge aclk);
        while (words_owed != 0) @(posedge aclk);
        // trailing edge adds leave no word behind
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [tsc_pkg::REG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_wdata <= val[6:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic set_graph(int parts, int ops);
        settle();
        write_reg(tsc_pkg::REG_PART_COUNT, parts);
        write_reg(tsc_pkg::REG_OPERATION_COUNT, ops);
        @(posedge aclk);
        cur_parts = parts;
        cur_ops = ops;
    endtask

    // edges only, the caller pushes the run; acyclic ones follow a random rank, noise words go anywhere
    task automatic edge_batch(int count, bit acyclic);
        int n, p, a, b, t;
        int rank[tsc_pkg::MAX_NODES];
        n = cur_parts + cur_ops;
        if (n > tsc_pkg::MAX_NODES) n = tsc_pkg::MAX_NODES;
        p = cur_parts > n ? n : cur_parts;
        for (int i = 0; i < tsc_pkg::MAX_NODES; i++) rank[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            if (p == 0 || p == n || $urandom_range(0, 6) == 0) begin
                a = $urandom_range(0, 63);
                b = $urandom_range(0, 63);
            end else begin
                a = $urandom_range(0, p - 1);
                b = $urandom_range(p, n - 1);
                if (acyclic ? rank[a] > rank[b] : $urandom_range(0, 1)) begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            push_word(tsc_pkg::KIND_ADD, a, b);
        end
    endtask

    initial begin
        int pc, oc, cnt;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty graph, rejections, in order, sort, cycle, extremes
        set_graph(0, 0);
        push_word(tsc_pkg::KIND_ADD, 0, 0);
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        set_graph(3, 3);
        push_word(tsc_pkg::KIND_ADD, 0, 1);
        push_word(tsc_pkg::KIND_ADD, 63, 0);
        push_word(tsc_pkg::KIND_ADD, 0, 3);
        push_word(tsc_pkg::KIND_ADD, 3, 1);
        push_word(tsc_pkg::KIND_RUN, 63, 63);
        push_word(tsc_pkg::KIND_ADD, 1, 3);
        push_word(tsc_pkg::KIND_ADD, 3, 0);
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        push_word(tsc_pkg::KIND_ADD, 0, 3);
        push_word(tsc_pkg::KIND_ADD, 3, 0);
        push_word(tsc_pkg::KIND_ADD, 4, 2);
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        set_graph(32, 32);
        push_word(tsc_pkg::KIND_ADD, 31, 63);
        push_word(tsc_pkg::KIND_ADD, 63, 31);
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        // stale edges: registers change between load and run
        push_word(tsc_pkg::KIND_ADD, 5, 40);
        push_word(tsc_pkg::KIND_ADD, 40, 6);
        set_graph(64, 0);
        push_word(tsc_pkg::KIND_ADD, 0, 1);
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        set_graph(127, 127);
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        set_graph(0, 64);
        push_word(tsc_pkg::KIND_RUN, 0, 0);

        // full edge store, with the output held off meanwhile
        set_graph(32, 32);
        hold_req = 1;
        edge_batch(262, $urandom_range(0, 1));
        push_word(tsc_pkg::KIND_RUN, 0, 0);
        for (int i = 0; i < 6; i++) push_word(tsc_pkg::KIND_ADD, 0, 1);
        push_word(tsc_pkg::KIND_RUN, 0, 0);

        while (sent < ITEM_GOAL) begin
            if ($urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    pc = $urandom_range(0, 127);
                    oc = $urandom_range(0, 127);
                end else begin
                    pc = $urandom_range(0, 7);
                    oc = $urandom_range(0, 7);
                end
                set_graph(pc, oc);
            end
            if (sent > ITEM_GOAL - 60) quiet = 1;
            cnt = $urandom_range(0, 24);
            edge_batch(cnt, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0)
                set_graph($urandom_range(0, 8), $urandom_range(0, 8));
            push_word(tsc_pkg::KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
        end

        quiet = 1;
        settle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && words_owed == 0)
            $display("topological_sort_with_cycle_find verification clean");
        else
            $display("topological_sort_with_cycle_find verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/tsc_pkg.sv
sv/tsc_ram.sv
sv/tsc_edge_store.sv
sv/tsc_ctrl.sv
sv/topological_sort_with_cycle_find.sv
sv/tsc_checker.sv
dv/topological_sort_with_cycle_find_checker.sv
dv/topological_sort_with_cycle_find_test.sv
